[rtl/core/rgd_pkg.sv]
// Shared types and constants for the rocking gesture detector.
`default_nettype none

package rgd_pkg;

    // Direction code of the screen tilt after the dead band
    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_POS  = 2'd1,
        DIR_NEG  = 2'd3
    } t_dir;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_TILT_THRESHOLD = 3'd0,
        CFG_SAMPLE_PERIOD  = 3'd1,
        CFG_SWING_WINDOW   = 3'd2,
        CFG_LULLABY_WINDOW = 3'd3,
        CFG_LULLABY_COOL   = 3'd4,
        CFG_FUN_COOL       = 3'd5,
        CFG_LULLABY_SWINGS = 3'd6,
        CFG_FUN_SWINGS     = 3'd7
    } t_cfg_idx;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int THR_BITS      = 15;
    localparam int MS_BITS       = 16;
    localparam int CNT_BITS      = 8;

    // Reset values of the configuration registers
    localparam logic [THR_BITS-1:0] RST_TILT_THRESHOLD = 15'd410;
    localparam logic [MS_BITS-1:0]  RST_SAMPLE_PERIOD  = 16'd200;
    localparam logic [MS_BITS-1:0]  RST_SWING_WINDOW   = 16'd3000;
    localparam logic [MS_BITS-1:0]  RST_LULLABY_WINDOW = 16'd10000;
    localparam logic [MS_BITS-1:0]  RST_LULLABY_COOL   = 16'd15000;
    localparam logic [MS_BITS-1:0]  RST_FUN_COOL       = 16'd1500;
    localparam logic [CNT_BITS-1:0] RST_LULLABY_SWINGS = 8'd6;
    localparam logic [CNT_BITS-1:0] RST_FUN_SWINGS     = 8'd2;

    // Swing counters stop at this value
    localparam logic [CNT_BITS-1:0] CNT_MAX = 8'd255;

endpackage

`default_nettype wire

[rtl/core/rocking_gesture_detector.sv]
// Rocking gesture detector: direction quantizer, swing windows and event logic.
// An accepted sample's result is loaded into the output register, valid in the cycle after it is accepted.
// Throughput: one sample per cycle while o_stall is low; the whole step is a single
// pass of compare and subtract logic from the state registers into the state and result registers.
// o_stall is high only while the result register holds a transaction that is stalled.
// Reset (synchronous, active low) loads the register defaults and clears the detector state and output valid.
`default_nettype none

module rocking_gesture_detector
    import rgd_pkg::*;
#(
    parameter int TIME_BITS = 32,
    parameter int TILT_BITS = 16
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    // configuration write port
    input  wire                       i_cfg_we,
    input  wire  [CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire  [CFG_DATA_BITS-1:0]  i_cfg_data,
    // sample channel
    input  wire                       i_valid,
    output logic                      o_stall,
    input  wire  [TIME_BITS-1:0]      i_time_ms,
    input  wire signed [TILT_BITS-1:0] i_tilt_x,
    input  wire                       i_asleep,
    // result channel
    output logic                      o_valid,
    input  wire                       i_stall,
    output logic                      o_fun_event,
    output logic                      o_lullaby_event
);

    localparam int CW = ((TILT_BITS > THR_BITS) ? TILT_BITS : THR_BITS) + 2;

    // configuration registers
    logic [THR_BITS-1:0] r_tilt_thr;
    logic [MS_BITS-1:0]  r_period, r_swin, r_lwin, r_lcool, r_fcool;
    logic [CNT_BITS-1:0] r_lswings, r_fswings;

    // detector state
    logic [TIME_BITS-1:0] r_last_sample, n_last_sample;
    logic [TIME_BITS-1:0] r_check, n_check;
    t_dir                 r_dir, n_dir;
    logic [CNT_BITS-1:0]  r_s_cnt, n_s_cnt;
    logic [TIME_BITS-1:0] r_s_start, n_s_start;
    logic [CNT_BITS-1:0]  r_l_cnt, n_l_cnt;
    logic [TIME_BITS-1:0] r_l_start, n_l_start;
    logic [TIME_BITS-1:0] r_lull_time, n_lull_time;
    logic [TIME_BITS-1:0] r_fun_time, n_fun_time;

    // result register
    logic r_out_valid, r_fun, r_lull;
    logic n_fun, n_lull;

    logic in_acc;

    // step intermediates
    logic [TIME_BITS-1:0] chk;
    logic                 do_check;
    t_dir                 dir_q;
    logic signed [CW-1:0] tilt_ext, thr_ext;
    logic                 rev, s_exp_pre, l_exp_pre, s_restart, l_restart;
    logic                 s_exp2, l_exp2, cooled, fun_cool_ok;
    logic [CNT_BITS-1:0]  s_cnt1, l_cnt1, s_cnt2, l_cnt2;
    logic [TIME_BITS-1:0] s_start1, l_start1;
    t_dir                 dir1, dir2;

    assign in_acc  = i_valid && !o_stall;
    assign o_stall = r_out_valid && i_stall;

    assign o_valid         = r_out_valid;
    assign o_fun_event     = r_fun;
    assign o_lullaby_event = r_lull;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tilt_thr <= RST_TILT_THRESHOLD;
            r_period   <= RST_SAMPLE_PERIOD;
            r_swin     <= RST_SWING_WINDOW;
            r_lwin     <= RST_LULLABY_WINDOW;
            r_lcool    <= RST_LULLABY_COOL;
            r_fcool    <= RST_FUN_COOL;
            r_lswings  <= RST_LULLABY_SWINGS;
            r_fswings  <= RST_FUN_SWINGS;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TILT_THRESHOLD: r_tilt_thr <= i_cfg_data[THR_BITS-1:0];
                CFG_SAMPLE_PERIOD:  r_period   <= i_cfg_data;
                CFG_SWING_WINDOW:   r_swin     <= i_cfg_data;
                CFG_LULLABY_WINDOW: r_lwin     <= i_cfg_data;
                CFG_LULLABY_COOL:   r_lcool    <= i_cfg_data;
                CFG_FUN_COOL:       r_fcool    <= i_cfg_data;
                CFG_LULLABY_SWINGS: r_lswings  <= i_cfg_data[CNT_BITS-1:0];
                CFG_FUN_SWINGS:     r_fswings  <= i_cfg_data[CNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // quantize tilt to a screen direction with a dead band
    always_comb begin
        tilt_ext = CW'(i_tilt_x);
        thr_ext  = $signed(CW'(r_tilt_thr));
        if (tilt_ext < -thr_ext) begin
            dir_q = DIR_POS;
        end else if (tilt_ext > thr_ext) begin
            dir_q = DIR_NEG;
        end else begin
            dir_q = DIR_NONE;
        end
    end

    // one detector step on the incoming sample
    always_comb begin
        chk       = (r_check == '0) ? i_time_ms : r_check;
        do_check  = (i_time_ms - chk) >= TIME_BITS'(r_period);

        rev       = (dir_q != DIR_NONE) && (dir_q != r_dir) && (r_dir != DIR_NONE);
        s_exp_pre = (i_time_ms - r_s_start) > TIME_BITS'(r_swin);
        l_exp_pre = (i_time_ms - r_l_start) > TIME_BITS'(r_lwin);
        s_restart = rev && ((r_s_cnt == '0) || s_exp_pre);
        l_restart = rev && ((r_l_cnt == '0) || l_exp_pre);

        // count reversals, restarting a window when empty or passed
        s_start1 = s_restart ? i_time_ms : r_s_start;
        l_start1 = l_restart ? i_time_ms : r_l_start;
        if (s_restart) begin
            s_cnt1 = CNT_BITS'(1);
        end else if (rev && (r_s_cnt != CNT_MAX)) begin
            s_cnt1 = r_s_cnt + CNT_BITS'(1);
        end else begin
            s_cnt1 = r_s_cnt;
        end
        if (l_restart) begin
            l_cnt1 = CNT_BITS'(1);
        end else if (rev && (r_l_cnt != CNT_MAX)) begin
            l_cnt1 = r_l_cnt + CNT_BITS'(1);
        end else begin
            l_cnt1 = r_l_cnt;
        end
        dir1 = ((dir_q != DIR_NONE) && (dir_q != r_dir)) ? dir_q : r_dir;

        // expire windows; a window restarted now has not passed
        s_exp2 = (s_cnt1 != '0) && !s_restart && s_exp_pre;
        l_exp2 = (l_cnt1 != '0) && !l_restart && l_exp_pre;
        s_cnt2 = s_exp2 ? '0 : s_cnt1;
        l_cnt2 = l_exp2 ? '0 : l_cnt1;
        dir2   = s_exp2 ? DIR_NONE : dir1;

        // pick the event, lullaby first
        cooled      = (r_lull_time == '0) ||
                      ((i_time_ms - r_lull_time) > TIME_BITS'(r_lcool));
        fun_cool_ok = (i_time_ms - r_fun_time) > TIME_BITS'(r_fcool);

        // hold state by default; always record the sample time, no event
        n_last_sample = i_time_ms;
        n_check       = r_check;
        n_dir         = r_dir;
        n_s_cnt       = r_s_cnt;
        n_s_start     = r_s_start;
        n_l_cnt       = r_l_cnt;
        n_l_start     = r_l_start;
        n_lull_time   = r_lull_time;
        n_fun_time    = r_fun_time;
        n_fun         = 1'b0;
        n_lull        = 1'b0;

        if (r_last_sample == '0) begin
            // first sample only records the time
        end else if (i_asleep) begin
            n_check = '0;
            n_dir   = DIR_NONE;
            n_s_cnt = '0;
            n_l_cnt = '0;
        end else if (!do_check) begin
            n_check = chk;
        end else begin
            n_check   = i_time_ms;
            n_s_start = s_start1;
            n_l_start = l_start1;
            n_s_cnt   = s_cnt2;
            n_l_cnt   = l_cnt2;
            n_dir     = dir2;
            if ((l_cnt2 >= r_lswings) && cooled) begin
                n_lull      = 1'b1;
                n_lull_time = i_time_ms;
                n_l_cnt     = '0;
                n_s_cnt     = '0;
                n_dir       = DIR_NONE;
            end else if ((s_cnt2 >= r_fswings) && fun_cool_ok) begin
                n_fun      = 1'b1;
                n_fun_time = i_time_ms;
                n_s_cnt    = '0;
                n_dir      = DIR_NONE;
            end
        end
    end

    // advance state on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_sample <= '0;
            r_check       <= '0;
            r_dir         <= DIR_NONE;
            r_s_cnt       <= '0;
            r_s_start     <= '0;
            r_l_cnt       <= '0;
            r_l_start     <= '0;
            r_lull_time   <= '0;
            r_fun_time    <= '0;
        end else if (in_acc) begin
            r_last_sample <= n_last_sample;
            r_check       <= n_check;
            r_dir         <= n_dir;
            r_s_cnt       <= n_s_cnt;
            r_s_start     <= n_s_start;
            r_l_cnt       <= n_l_cnt;
            r_l_start     <= n_l_start;
            r_lull_time   <= n_lull_time;
            r_fun_time    <= n_fun_time;
        end
    end

    // result register: load on accept, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_fun  <= n_fun;
            r_lull <= n_lull;
        end
    end

    // checks
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_fun_event && o_lullaby_event))
        else $error("fun and lullaby events on the same result");

    a_sleep_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_asleep && (r_last_sample != '0)) |=>
        ((r_s_cnt == '0) && (r_l_cnt == '0) && (r_dir == DIR_NONE) && !o_fun_event
         && !o_lullaby_event))
        else $error("sleeping sample left counters or fired an event");

    a_event_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (n_fun || n_lull)) |=> ((r_s_cnt == '0) && (r_dir == DIR_NONE)))
        else $error("event did not clear the short count and direction");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_valid)
        else $error("accepted sample produced no result");

endmodule

`default_nettype wire
